// File: rtl/core/igm_pkg.sv
// ----------------------------------------------------------------------------
// igm_pkg
// Shared constants, codes and types of the incremental Gram matrix block.
// ----------------------------------------------------------------------------
package igm_pkg;

  localparam int HIST     = 8;
  localparam int MAX_LEN  = 4096;
  localparam int HIST_W   = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int POS_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W    = $clog2(HIST + 1);
  localparam int LEN_W    = 13;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int DOT_W    = 48;
  localparam int GRAM_AW  = 2 * HIST_W;
  localparam int VEC_AW   = HIST_W + POS_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  localparam logic REG_VLEN = 1'b0;

  typedef struct packed {
    logic              mul_en;
    logic [HIST_W-1:0] mul_idx;
    logic              zero_en;
    logic [HIST_W-1:0] zero_idx;
    logic              clear_all;
  } mac_ctrl_t;

endpackage

// File: rtl/core/igm_ram.sv
// ----------------------------------------------------------------------------
// igm_ram
// Single-port synchronous RAM, read data registered.
// ----------------------------------------------------------------------------
module igm_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/igm_mac.sv
// ----------------------------------------------------------------------------
// igm_mac
// Registered 16x16 multiplier followed by the per-slot 48-bit partial sums.
// ----------------------------------------------------------------------------
module igm_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  igm_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [igm_pkg::ELEM_W-1:0]     op_a_i,
  input  logic signed [igm_pkg::ELEM_W-1:0]     op_b_i,
  input  logic        [igm_pkg::HIST_W-1:0]     rd_idx_i,
  output logic        [igm_pkg::DOT_W-1:0]      rd_data_o
);
  import igm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic [HIST_W-1:0]        prod_idx_q;
  logic [DOT_W-1:0]         psum_q [HIST];

  always_ff @(posedge clk_i) begin
    prod_q     <= op_a_i * op_b_i;
    prod_idx_q <= ctrl_i.mul_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      for (int i = 0; i < HIST; i++) begin
        psum_q[i] <= '0;
      end
    end else begin
      prod_v_q <= ctrl_i.mul_en;
      if (ctrl_i.clear_all) begin
        for (int i = 0; i < HIST; i++) begin
          psum_q[i] <= '0;
        end
      end else begin
        if (prod_v_q) begin
          psum_q[prod_idx_q] <= psum_q[prod_idx_q] + DOT_W'(prod_q);
        end
        if (ctrl_i.zero_en) begin
          psum_q[ctrl_i.zero_idx] <= '0;
        end
      end
    end
  end

  assign rd_data_o = psum_q[rd_idx_i];

endmodule

// File: rtl/core/igm_cfg.sv
// ----------------------------------------------------------------------------
// igm_cfg
// APB register file: vector length register and its clamped effective value.
// ----------------------------------------------------------------------------
module igm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [igm_pkg::APB_AW-1:0]  paddr,
  input  logic [igm_pkg::APB_DW-1:0]  pwdata,
  output logic [igm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [igm_pkg::LEN_W-1:0]   eff_len_o
);
  import igm_pkg::*;

  logic [LEN_W-1:0] vlen_q;
  logic             wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_VLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= LEN_W'(MAX_LEN);
    end else if (wr_en) begin
      vlen_q <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (vlen_q == '0) begin
      eff_len_o = LEN_W'(1);
    end else if (vlen_q > LEN_W'(MAX_LEN)) begin
      eff_len_o = LEN_W'(MAX_LEN);
    end else begin
      eff_len_o = vlen_q;
    end
  end

  assign prdata = (paddr[2] == REG_VLEN) ? APB_DW'(vlen_q) : '0;
  assign pready = 1'b1;

endmodule

// File: rtl/core/incremental_gram_matrix.sv
// ----------------------------------------------------------------------------
// incremental_gram_matrix
// Streams vector elements, keeps up to HIST vectors and their Gram matrix.
//
//   channel  | handshake                         | payload
//   command  | start, busy                       | action, element, row, col
//   result   | result_valid_o (one-cycle strobe) | kind, status, index, dot, last
//   config   | APB psel/penable/pwrite, pready=1 | vector_length at 0x0
//
// Push of a non-final element: one vector memory access per slot for the n
// stored vectors and the new one, then a drain of multiplier and accumulator.
// Final element adds the Gram write-back, ST_FIN_A then ST_FIN_B per slot, the
// new vector included.
// Clear, reject and out-of-range read are answered from idle; a read passes ST_RD.
// Reset clears control state and partial sums; memories need no clearing.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module incremental_gram_matrix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic signed [igm_pkg::ELEM_W-1:0]  element_value_i,
  input  logic [igm_pkg::HIST_W-1:0]         row_index_i,
  input  logic [igm_pkg::HIST_W-1:0]         col_index_i,
  output logic                               result_valid_o,
  output logic [1:0]                         kind_o,
  output logic [1:0]                         status_o,
  output logic [igm_pkg::HIST_W-1:0]         entry_index_o,
  output logic signed [igm_pkg::DOT_W-1:0]   dot_value_o,
  output logic                               last_result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [igm_pkg::APB_AW-1:0]         paddr,
  input  logic [igm_pkg::APB_DW-1:0]         pwdata,
  output logic [igm_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import igm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN_A,
    ST_FIN_B,
    ST_RD
  } state_e;

  state_e                    state_q;
  logic signed [ELEM_W-1:0]  x_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [POS_W-1:0]          pos_q;
  logic [HIST_W-1:0]         slot_q;
  logic                      drain_q;
  logic                      s1_v_q;
  logic                      s1_self_q;
  logic [HIST_W-1:0]         s1_idx_q;
  logic [HIST_W-1:0]         rd_col_q;

  logic                      res_v_q;
  logic [1:0]                res_kind_q;
  logic [1:0]                res_status_q;
  logic [HIST_W-1:0]         res_idx_q;
  logic [DOT_W-1:0]          res_dot_q;
  logic                      res_last_q;

  logic                      accept;
  logic [HIST_W-1:0]         top_slot;
  logic                      is_top;
  logic                      full;
  logic                      in_range;
  logic                      vector_end;
  logic [LEN_W-1:0]          eff_len;

  logic                      vec_we;
  logic [VEC_AW-1:0]         vec_addr;
  logic [ELEM_W-1:0]         vec_rdata;
  logic                      gram_we;
  logic [GRAM_AW-1:0]        gram_addr;
  logic [DOT_W-1:0]          gram_rdata;
  logic [DOT_W-1:0]          psum_rd;
  mac_ctrl_t                 mac_ctrl;
  logic signed [ELEM_W-1:0]  mac_op_a;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign top_slot   = cnt_q[HIST_W-1:0];
  assign is_top     = (slot_q == top_slot);
  assign full       = (cnt_q == CNT_W'(HIST));
  assign in_range   = (CNT_W'(row_index_i) < cnt_q) && (CNT_W'(col_index_i) < cnt_q);
  assign vector_end = (LEN_W'(pos_q) + LEN_W'(1)) >= eff_len;

  assign vec_we   = (state_q == ST_MAC) && is_top;
  assign vec_addr = {slot_q, pos_q};
  assign mac_op_a = s1_self_q ? x_q : $signed(vec_rdata);

  always_comb begin
    gram_we   = 1'b0;
    gram_addr = {row_index_i, col_index_i};
    unique case (state_q)
      ST_FIN_A: begin
        gram_we   = 1'b1;
        gram_addr = {top_slot, slot_q};
      end
      ST_FIN_B: begin
        gram_we   = 1'b1;
        gram_addr = {slot_q, top_slot};
      end
      default: begin
        gram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.mul_en    = s1_v_q;
    mac_ctrl.mul_idx   = s1_idx_q;
    mac_ctrl.zero_en   = (state_q == ST_FIN_B);
    mac_ctrl.zero_idx  = slot_q;
    mac_ctrl.clear_all = accept && (action_i == ACT_CLEAR);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= element_value_i;
      rd_col_q <= col_index_i;
    end
    s1_idx_q  <= slot_q;
    s1_self_q <= is_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pos_q        <= '0;
      slot_q       <= '0;
      drain_q      <= 1'b0;
      s1_v_q       <= 1'b0;
      res_v_q      <= 1'b0;
      res_kind_q   <= KIND_PUSH;
      res_status_q <= STS_OK;
      res_idx_q    <= '0;
      res_dot_q    <= '0;
      res_last_q   <= 1'b0;
    end else begin
      res_v_q    <= 1'b0;
      res_idx_q  <= '0;
      res_dot_q  <= '0;
      res_last_q <= 1'b1;
      s1_v_q     <= (state_q == ST_MAC);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (action_i)
              ACT_PUSH: begin
                if (full) begin
                  res_v_q      <= 1'b1;
                  res_kind_q   <= KIND_PUSH;
                  res_status_q <= STS_FULL;
                end else begin
                  slot_q  <= '0;
                  state_q <= ST_MAC;
                end
              end
              ACT_CLEAR: begin
                cnt_q        <= '0;
                pos_q        <= '0;
                res_v_q      <= 1'b1;
                res_kind_q   <= KIND_CLEAR;
                res_status_q <= STS_OK;
              end
              ACT_READ: begin
                if (in_range) begin
                  state_q <= ST_RD;
                end else begin
                  res_v_q      <= 1'b1;
                  res_kind_q   <= KIND_READ;
                  res_status_q <= STS_RANGE;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MAC: begin
          if (is_top) begin
            drain_q <= 1'b0;
            state_q <= ST_DRAIN;
          end else begin
            slot_q <= slot_q + HIST_W'(1);
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            slot_q <= '0;
            if (vector_end) begin
              state_q <= ST_FIN_A;
            end else begin
              pos_q   <= pos_q + POS_W'(1);
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FIN_A: begin
          res_v_q      <= 1'b1;
          res_kind_q   <= KIND_PUSH;
          res_status_q <= STS_OK;
          res_idx_q    <= slot_q;
          res_dot_q    <= psum_rd;
          res_last_q   <= is_top;
          state_q      <= ST_FIN_B;
        end
        ST_FIN_B: begin
          if (is_top) begin
            cnt_q   <= cnt_q + CNT_W'(1);
            pos_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            slot_q  <= slot_q + HIST_W'(1);
            state_q <= ST_FIN_A;
          end
        end
        ST_RD: begin
          res_v_q      <= 1'b1;
          res_kind_q   <= KIND_READ;
          res_status_q <= STS_OK;
          res_idx_q    <= rd_col_q;
          res_dot_q    <= gram_rdata;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_v_q;
  assign kind_o         = res_kind_q;
  assign status_o       = res_status_q;
  assign entry_index_o  = res_idx_q;
  assign dot_value_o    = $signed(res_dot_q);
  assign last_result_o  = res_last_q;

  igm_ram #(
    .ADDR_W (VEC_AW),
    .DATA_W (ELEM_W)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .addr_i  (vec_addr),
    .wdata_i (x_q),
    .rdata_o (vec_rdata)
  );

  igm_ram #(
    .ADDR_W (GRAM_AW),
    .DATA_W (DOT_W)
  ) u_gram_ram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .addr_i  (gram_addr),
    .wdata_i (psum_rd),
    .rdata_o (gram_rdata)
  );

  igm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .op_a_i    (mac_op_a),
    .op_b_i    (x_q),
    .rd_idx_i  (slot_q),
    .rd_data_o (psum_rd)
  );

  igm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_len_o (eff_len)
  );

endmodule

// File: rtl/core/igm_checker.sv
// ----------------------------------------------------------------------------
// igm_checker
// Port-level checks of the incremental Gram matrix block, bound to the top.
// ----------------------------------------------------------------------------
module igm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  action_i,
  input logic                        result_valid_o,
  input logic [1:0]                  kind_o,
  input logic [1:0]                  status_o,
  input logic [igm_pkg::DOT_W-1:0]   dot_value_o,
  input logic                        last_result_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [igm_pkg::APB_AW-1:0]  paddr,
  input logic [igm_pkg::APB_DW-1:0]  pwdata,
  input logic [igm_pkg::APB_DW-1:0]  prdata
);
  import igm_pkg::*;

  a_clear_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && action_i == ACT_CLEAR |=>
      result_valid_o && kind_o == KIND_CLEAR && last_result_o)
    else $error("clear transaction not acknowledged");

  a_push_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && action_i == ACT_PUSH |=> busy || result_valid_o)
    else $error("push transaction neither started nor rejected");

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STS_FULL |-> dot_value_o == '0 && last_result_o)
    else $error("rejected push carries data");

  a_vlen_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == REG_VLEN |=>
      prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]) || paddr[2] != REG_VLEN)
    else $error("vector length write not returned on read");

endmodule

bind incremental_gram_matrix igm_checker u_igm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .status_o       (status_o),
  .dot_value_o    (dot_value_o),
  .last_result_o  (last_result_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

// File: tb/igm_checker.sv
// ----------------------------------------------------------------------------
// igm_scoreboard
// Watches the command, result and register ports of the incremental Gram
// matrix block, predicts every result transaction from its own copy of the
// vector history, partial sums and matrix, and compares each result field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module igm_scoreboard (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic signed [igm_pkg::ELEM_W-1:0]  element_value_i,
  input  logic [igm_pkg::HIST_W-1:0]         row_index_i,
  input  logic [igm_pkg::HIST_W-1:0]         col_index_i,
  input  logic                               result_valid_o,
  input  logic [1:0]                         kind_o,
  input  logic [1:0]                         status_o,
  input  logic [igm_pkg::HIST_W-1:0]         entry_index_o,
  input  logic signed [igm_pkg::DOT_W-1:0]   dot_value_o,
  input  logic                               last_result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [igm_pkg::APB_AW-1:0]         paddr,
  input  logic [igm_pkg::APB_DW-1:0]         pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 pending
);
  import igm_pkg::*;

  typedef struct {
    kind_e             kind;
    status_e           status;
    logic [HIST_W-1:0] idx;
    logic [DOT_W-1:0]  dot;
    logic              last;
  } gram_result_t;

  gram_result_t            gram_results_due[$];
  logic signed [ELEM_W-1:0] history_mem [HIST][MAX_LEN];
  logic [DOT_W-1:0]        gram_mem [HIST][HIST];
  logic [DOT_W-1:0]        dot_sums [HIST];
  int                      elem_pos;
  int                      stored;
  logic [LEN_W-1:0]        vec_len;

  function automatic gram_result_t make_result(kind_e k, status_e s, int idx,
                                               logic [DOT_W-1:0] dot, logic last);
    gram_result_t res;
    res.kind   = k;
    res.status = s;
    res.idx    = idx[HIST_W-1:0];
    res.dot    = dot;
    res.last   = last;
    return res;
  endfunction

  function automatic void enqueue_result(gram_result_t res);
    gram_results_due.insert(gram_results_due.size(), res);
  endfunction

  task automatic predict_command(input logic [1:0] act, input logic signed [ELEM_W-1:0] x,
                                 input int r, input int c);
    int                       p;
    int                       eff;
    int                       i;
    logic signed [PROD_W-1:0] prod;
    case (action_e'(act))
      ACT_PUSH: begin
        if (stored >= HIST) begin
          enqueue_result(make_result(KIND_PUSH, STS_FULL, 0, '0, 1'b1));
        end else begin
          p = (elem_pos >= MAX_LEN) ? MAX_LEN - 1 : elem_pos;
          history_mem[stored][p] = x;
          for (i = 0; i <= stored; i++) begin
            prod = history_mem[i][p] * x;
            dot_sums[i] = dot_sums[i] + {{(DOT_W-PROD_W){prod[PROD_W-1]}}, prod};
          end
          eff = (vec_len == 0) ? 1 : (vec_len > MAX_LEN) ? MAX_LEN : int'(vec_len);
          if (p + 1 < eff) begin
            elem_pos = p + 1;
          end else begin
            for (i = 0; i <= stored; i++) begin
              gram_mem[stored][i] = dot_sums[i];
              gram_mem[i][stored] = dot_sums[i];
              enqueue_result(make_result(KIND_PUSH, STS_OK, i, dot_sums[i], i == stored));
              dot_sums[i] = '0;
            end
            elem_pos = 0;
            stored++;
          end
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < HIST; i++) dot_sums[i] = '0;
        elem_pos = 0;
        stored   = 0;
        enqueue_result(make_result(KIND_CLEAR, STS_OK, 0, '0, 1'b1));
      end
      ACT_READ: begin
        if (r >= stored || c >= stored) begin
          enqueue_result(make_result(KIND_READ, STS_RANGE, 0, '0, 1'b1));
        end else begin
          enqueue_result(make_result(KIND_READ, STS_OK, c, gram_mem[r][c], 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint exp_val, input longint got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  task automatic check_result();
    gram_result_t exp_res;
    if (gram_results_due.size() == 0) begin
      $error("unexpected result transaction: kind %0d status %0d index %0d",
             kind_o, status_o, entry_index_o);
      fail_count++;
    end else begin
      exp_res = gram_results_due.pop_front();
      check_field("kind", longint'(exp_res.kind), longint'(kind_o));
      check_field("status", longint'(exp_res.status), longint'(status_o));
      check_field("entry_index", longint'(exp_res.idx), longint'(entry_index_o));
      check_field("dot_value", longint'($signed(exp_res.dot)), longint'(dot_value_o));
      check_field("last_result", longint'(exp_res.last), longint'(last_result_o));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_results_due.delete();
      for (int i = 0; i < HIST; i++) dot_sums[i] = '0;
      elem_pos   = 0;
      stored     = 0;
      vec_len    = LEN_W'(MAX_LEN);
      fail_count = 0;
      pending    = 0;
    end else begin
      if (result_valid_o) check_result();
      if (start && !busy) begin
        predict_command(action_i, element_value_i, int'(row_index_i), int'(col_index_i));
      end
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_VLEN) begin
        vec_len = pwdata[LEN_W-1:0];
      end
      pending = gram_results_due.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the incremental Gram matrix block: drives directed and random
// command transactions in bursts, programs the vector length over the
// register port between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import igm_pkg::*;

  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         RANDOM_ITEMS = 450;
  localparam int         LONG_PREFIX  = 24;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         DRAIN_CYCLES = 40;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_VLEN   = APB_AW'({REG_VLEN, 2'b00});
  localparam logic [APB_AW-1:0] ADDR_UNUSED = APB_AW'(4);

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                action_i;
  logic signed [ELEM_W-1:0]  element_value_i;
  logic [HIST_W-1:0]         row_index_i;
  logic [HIST_W-1:0]         col_index_i;
  logic                      result_valid_o;
  logic [1:0]                kind_o;
  logic [1:0]                status_o;
  logic [HIST_W-1:0]         entry_index_o;
  logic signed [DOT_W-1:0]   dot_value_o;
  logic                      last_result_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  int                        fail_count;
  int                        pending;
  int                        cycle_count = 0;

  int n_stored;
  int elem_pos;
  int eff_len;
  int written_len [HIST];
  int burst_left;
  int random_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  incremental_gram_matrix u_top (
    .clk_i, .rst_ni, .start, .busy, .action_i, .element_value_i, .row_index_i,
    .col_index_i, .result_valid_o, .kind_o, .status_o, .entry_index_o, .dot_value_o,
    .last_result_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  igm_scoreboard u_checker (
    .clk_i, .rst_ni, .start, .busy, .action_i, .element_value_i, .row_index_i,
    .col_index_i, .result_valid_o, .kind_o, .status_o, .entry_index_o, .dot_value_o,
    .last_result_o, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Track history occupancy so no push reads a vector slot never written.
  function automatic bit push_reads_written();
    int p;
    p = (elem_pos >= MAX_LEN) ? MAX_LEN - 1 : elem_pos;
    if (n_stored >= HIST) return 1'b1;
    for (int i = 0; i < n_stored; i++) begin
      if (written_len[i] <= p) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void track_command(logic [1:0] act);
    int p;
    if (act == ACT_PUSH && n_stored < HIST) begin
      p = (elem_pos >= MAX_LEN) ? MAX_LEN - 1 : elem_pos;
      if (written_len[n_stored] < p + 1) written_len[n_stored] = p + 1;
      if (p + 1 >= eff_len) begin
        n_stored++;
        elem_pos = 0;
      end else begin
        elem_pos = p + 1;
      end
    end else if (act == ACT_CLEAR) begin
      n_stored = 0;
      elem_pos = 0;
    end
  endfunction

  task automatic send(input logic [1:0] act, input logic signed [ELEM_W-1:0] x,
                      input logic [HIST_W-1:0] r, input logic [HIST_W-1:0] c);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      start           = 1'b0;
      action_i        = 2'($urandom);
      element_value_i = ELEM_W'($urandom);
      row_index_i     = HIST_W'($urandom);
      col_index_i     = HIST_W'($urandom);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    start           = 1'b1;
    action_i        = act;
    element_value_i = x;
    row_index_i     = r;
    col_index_i     = c;
    do @(posedge clk_i); while (busy);
    burst_left--;
    track_command(act);
  endtask

  task automatic push(input logic signed [ELEM_W-1:0] x);
    if (push_reads_written()) send(ACT_PUSH, x, HIST_W'($urandom), HIST_W'($urandom));
    else send(ACT_CLEAR, x, HIST_W'($urandom), HIST_W'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_length(input logic [APB_DW-1:0] value);
    logic [LEN_W-1:0] raw;
    apb_write(ADDR_VLEN, value);
    raw     = value[LEN_W-1:0];
    eff_len = (raw == 0) ? 1 : (raw > MAX_LEN) ? MAX_LEN : int'(raw);
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [APB_DW-1:0] len_value;
    int                sel;
    int                row;
    start           = 1'b0;
    action_i        = ACT_PUSH;
    element_value_i = '0;
    row_index_i     = '0;
    col_index_i     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    n_stored        = 0;
    elem_pos        = 0;
    eff_len         = MAX_LEN;
    burst_left      = 0;
    random_count    = 0;
    for (int i = 0; i < HIST; i++) written_len[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty history: read out of range, clear, unused action.
    send(ACT_READ, '0, 3'd0, 3'd0);
    send(ACT_CLEAR, '0, '0, '0);
    send(ACT_UNUSED, 16'sh7FFF, 3'd7, 3'd7);
    // Two extreme two-element vectors, then reads in and out of range.
    set_length(2);
    push(16'sh7FFF);
    push(16'sh8000);
    push(16'sh8000);
    push(16'sh8000);
    send(ACT_READ, '0, 3'd1, 3'd0);
    send(ACT_READ, '0, 3'd1, 3'd1);
    send(ACT_READ, '0, 3'd7, 3'd7);
    // Zero length acts as one: fill the history, then hit the full case.
    set_length(0);
    push(16'sd1);
    push(-16'sd1);
    push(16'sd0);
    push(16'sh4000);
    push(16'sh8000);
    push(16'sh7FFF);
    push(16'sh1234);
    send(ACT_READ, '0, 3'd7, 3'd7);
    send(ACT_READ, '0, 3'd7, 3'd2);
    send(ACT_CLEAR, '0, '0, '0);

    // Long lengths: oversized length clamps, the exact maximum holds, and a
    // shorter length written mid vector ends it on the next element.
    set_length(32'h1FFF);
    repeat (LONG_PREFIX) push(rand_element());
    set_length(2);
    push(rand_element());
    set_length(MAX_LEN);
    repeat (LONG_PREFIX) push(rand_element());
    set_length(5);
    push(rand_element());
    send(ACT_READ, '0, 3'd1, 3'd0);

    while (random_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0:       len_value = 0;
        1:       len_value = 1;
        2:       len_value = {19'($urandom), 13'd3};
        3:       len_value = $urandom_range(6, 20);
        default: len_value = $urandom_range(2, 5);
      endcase
      if ($urandom_range(0, 7) == 0) apb_write(ADDR_UNUSED, $urandom);
      set_length(len_value);
      repeat ($urandom_range(15, 60)) begin
        sel = $urandom_range(0, 99);
        if (n_stored >= HIST && sel < 50) begin
          send(ACT_CLEAR, ELEM_W'($urandom), HIST_W'($urandom), HIST_W'($urandom));
        end else if (sel < 78) begin
          push(rand_element());
        end else if (sel < 92) begin
          row = (n_stored > 0 && sel < 86) ? $urandom_range(0, n_stored - 1) : $urandom_range(0, 7);
          send(ACT_READ, ELEM_W'($urandom), HIST_W'(row),
               HIST_W'((n_stored > 0 && sel < 86) ? $urandom_range(0, n_stored - 1)
                                                  : $urandom_range(0, 7)));
        end else if (sel < 96) begin
          send(ACT_CLEAR, ELEM_W'($urandom), HIST_W'($urandom), HIST_W'($urandom));
        end else begin
          send(ACT_UNUSED, ELEM_W'($urandom), HIST_W'($urandom), HIST_W'($urandom));
          random_count--;
        end
        random_count++;
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/igm_pkg.sv
rtl/core/igm_ram.sv
rtl/core/igm_mac.sv
rtl/core/igm_cfg.sv
rtl/core/incremental_gram_matrix.sv
rtl/core/igm_checker.sv
tb/igm_checker.sv
tb/tb_top.sv
